>>> src/length_prefixed_nal_to_start_code_assert.svh
// Assertion macros for the start-code framer.
// Used by the top level; expects clk and arst_n in scope.
`ifndef LENGTH_PREFIXED_NAL_TO_START_CODE_ASSERT_SVH
`define LENGTH_PREFIXED_NAL_TO_START_CODE_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define LPNAL_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset only.
`define LPNAL_HOLDS_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/lpnal_pkg.sv
// Shared types and constants of the start-code framer.
// No dependencies; used by all modules of the block.
package lpnal_pkg;

	localparam int LEN_W   = 32;
	localparam int CAP_W   = 24;
	localparam int ENTRY_W = 16;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam logic [2:0] HDR_SIZE_IDX   = 3'd4;
	localparam logic [2:0] HDR_COUNT_IDX  = 3'd5;
	localparam logic [2:0] LEN_SIZE_MAX   = 3'd5;
	localparam logic [4:0] SET_COUNT_MASK = 5'h1f;
	localparam logic [2:0] START_BYTES    = 3'd4;
	localparam logic [7:0] START_LAST     = 8'h01;

	typedef enum logic [1:0] {
		PH_LEN,
		PH_BODY,
		PH_TAIL
	} sphase_t;

	typedef enum logic [2:0] {
		RP_HEADER,
		RP_SLEN,
		RP_SBODY,
		RP_PCOUNT,
		RP_PLEN,
		RP_PBODY,
		RP_DONE
	} rphase_t;

	// One classified input item: what the back end has to emit for it.
	typedef struct packed {
		logic       start;
		logic       r1_valid;
		logic       r1_has;
		logic [7:0] r1_byte;
		logic [1:0] r1_status;
		logic       cut;
		logic       last;
	} cmd_t;

endpackage

>>> src/length_prefixed_nal_to_start_code.sv
// Top level of the length-prefixed NAL to start-code framer.
// Depends on lpnal_pkg, lpnal_front, lpnal_cmdq, lpnal_back and the assert header.

// One byte enters per push: configuration-record bytes (action 1) are walked
// as header, sequence sets and picture sets, and every set is emitted behind
// 00 00 00 01; sample bytes (action 0) are split by their length fields and
// every NAL is emitted behind 00 00 00 01, each result item is one output byte
// or a bare status item. Errors in a sample (bad length size, NAL too long,
// output capacity exceeded) produce one status item and the rest of that
// sample is dropped; end_mark flags the final item caused by a last byte.
// Rate: the front end takes one byte per cycle while full is low; the back
// end delivers one result item per cycle while its output is empty or popped,
// and a byte that opens a NAL or set also yields the start code items.
// The QUEUE_DEPTH-entry command queue absorbs that, and full rises while
// the back end drains start codes. out_capacity writes are accepted at once
// (cfg_ready is always high) and also reload the per-sample output budget.
// There is no clearing pass after reset.
module length_prefixed_nal_to_start_code #(
	parameter int SAMPLE_BITS = 24,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// input side
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	input  logic [23:0] sample_length,
	// result side
	output logic        empty,
	input  logic        pop,
	output logic        has_byte,
	output logic [7:0]  out_byte,
	output logic [1:0]  status,
	output logic        end_mark,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] out_capacity
);

	`include "length_prefixed_nal_to_start_code_assert.svh"

	lpnal_pkg::cmd_t cmd, head;
	logic            cmd_valid;
	logic            q_full, q_empty, q_rd;
	logic            accept;

	// accept whenever the queue has room; the front end never stalls otherwise
	assign full      = q_full;
	assign accept    = push && !q_full;
	assign cfg_ready = 1'b1;

	lpnal_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.action       (action),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.last_byte    (last_byte),
		.sample_length(sample_length),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (out_capacity),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd)
	);

	// hold classified items until the back end can expand them
	lpnal_cmdq #(
		.DEPTH(QUEUE_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_valid),
		.wr_cmd (cmd),
		.rd     (q_rd),
		.head   (head),
		.q_full (q_full),
		.q_empty(q_empty)
	);

	lpnal_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.has_byte(has_byte),
		.out_byte(out_byte),
		.status  (status),
		.end_mark(end_mark)
	);

	`LPNAL_HOLDS(a_error_has_no_byte, !empty && (status != lpnal_pkg::ST_OK), !has_byte, "error item carries a byte")
	`LPNAL_HOLDS(a_bare_item_zero, !empty && !has_byte, out_byte == 8'h00, "bare item with nonzero byte")
	`LPNAL_HOLDS(a_no_cmd_when_full, push && full, !cmd_valid, "command produced while queue full")
	`LPNAL_HOLDS_NEXT(a_drain_to_empty, q_empty && !empty && pop, empty, "result appeared from empty queue")

endmodule

>>> src/lpnal_front.sv
// Front end: parses record and sample bytes and classifies each item.
// Depends on lpnal_pkg.
module lpnal_front #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       action,
	input  logic [7:0]                 data_byte,
	input  logic                       first_byte,
	input  logic                       last_byte,
	input  logic [23:0]                sample_length,
	input  logic                       cfg_we,
	input  logic [lpnal_pkg::CAP_W-1:0] cfg_data,
	output logic                       cmd_valid,
	output lpnal_pkg::cmd_t            cmd
);

	localparam logic [31:0] SAMPLE_MASK = 32'((64'd1 << SAMPLE_BITS) - 64'd1);

	lpnal_pkg::sphase_t                 sphase_q, sp_n;
	logic [2:0]                         lseen_q, lseen_n;
	logic [lpnal_pkg::LEN_W-1:0]        nal_q, nal_n;
	logic [lpnal_pkg::LEN_W-1:0]        sl_q, sl_n;
	logic [lpnal_pkg::CAP_W-1:0]        ol_q, ol_n;
	logic [lpnal_pkg::CAP_W-1:0]        cap_q;
	logic [2:0]                         ls_q, ls_n;
	lpnal_pkg::rphase_t                 rp_q, rp_n, done_ph;
	logic [2:0]                         ridx_q, ridx_n;
	logic [7:0]                         sets_q, sets_n, sets_dec;
	logic [lpnal_pkg::ENTRY_W-1:0]      ent_q, ent_n;
	logic                               drop_q, drop_n;
	logic                               is_s;
	logic [lpnal_pkg::LEN_W:0]          sum4;
	logic [lpnal_pkg::CAP_W-1:0]        charge4, charge1;
	logic [31:0]                        slen_m;
	logic                               do_start, do_byte, do_err, do_cut, silent;
	logic [1:0]                         err_code;

	assign slen_m  = {8'd0, sample_length} & SAMPLE_MASK;
	assign charge4 = (ol_q > 24'd4) ? ol_q - 24'd4 : '0;
	assign charge1 = (ol_q > 24'd1) ? ol_q - 24'd1 : '0;

	always_comb begin
		sp_n     = sphase_q;
		lseen_n  = lseen_q;
		nal_n    = nal_q;
		sl_n     = sl_q;
		ol_n     = ol_q;
		ls_n     = ls_q;
		rp_n     = rp_q;
		ridx_n   = ridx_q;
		sets_n   = sets_q;
		ent_n    = ent_q;
		drop_n   = drop_q;
		do_start = 1'b0;
		do_byte  = 1'b0;
		do_err   = 1'b0;
		do_cut   = 1'b0;
		err_code = lpnal_pkg::ST_OK;
		is_s     = 1'b0;
		sets_dec = '0;
		done_ph  = lpnal_pkg::RP_DONE;
		sum4     = '0;
		if (action) begin
			if (first_byte) begin
				rp_n   = lpnal_pkg::RP_HEADER;
				ridx_n = '0;
				ls_n   = '0;
				sets_n = '0;
				ent_n  = '0;
			end
			is_s     = (rp_n == lpnal_pkg::RP_SLEN) || (rp_n == lpnal_pkg::RP_SBODY);
			sets_dec = (sets_n != 8'd0) ? sets_n - 8'd1 : sets_n;
			if (sets_dec != 8'd0)
				done_ph = is_s ? lpnal_pkg::RP_SLEN : lpnal_pkg::RP_PLEN;
			else
				done_ph = is_s ? lpnal_pkg::RP_PCOUNT : lpnal_pkg::RP_DONE;
			unique case (rp_n)
				lpnal_pkg::RP_HEADER: begin
					if (ridx_n == lpnal_pkg::HDR_SIZE_IDX)
						ls_n = {1'b0, data_byte[1:0]} + 3'd1;
					if (ridx_n == lpnal_pkg::HDR_COUNT_IDX) begin
						sets_n = {3'b000, data_byte[4:0] & lpnal_pkg::SET_COUNT_MASK};
						rp_n   = (sets_n != 8'd0) ? lpnal_pkg::RP_SLEN : lpnal_pkg::RP_PCOUNT;
						ridx_n = '0;
					end else begin
						ridx_n = ridx_n + 3'd1;
					end
				end
				lpnal_pkg::RP_SLEN, lpnal_pkg::RP_PLEN: begin
					if (ridx_n == 3'd0) begin
						ent_n  = {data_byte, 8'h00};
						ridx_n = 3'd1;
					end else begin
						ent_n    = ent_n | {8'h00, data_byte};
						ridx_n   = '0;
						do_start = 1'b1;
						ol_n     = charge4;
						if (ent_n != '0) begin
							rp_n = is_s ? lpnal_pkg::RP_SBODY : lpnal_pkg::RP_PBODY;
						end else begin
							sets_n = sets_dec;
							rp_n   = done_ph;
						end
					end
				end
				lpnal_pkg::RP_SBODY, lpnal_pkg::RP_PBODY: begin
					do_byte = 1'b1;
					ol_n    = charge1;
					ent_n   = ent_n - 16'd1;
					if (ent_n == '0) begin
						sets_n = sets_dec;
						rp_n   = done_ph;
						ridx_n = '0;
					end
				end
				lpnal_pkg::RP_PCOUNT: begin
					sets_n = data_byte;
					rp_n   = (data_byte != 8'd0) ? lpnal_pkg::RP_PLEN : lpnal_pkg::RP_DONE;
					ridx_n = '0;
				end
				default: begin
				end
			endcase
		end else begin
			if (first_byte) begin
				sl_n    = slen_m;
				sp_n    = lpnal_pkg::PH_LEN;
				lseen_n = '0;
				nal_n   = '0;
				drop_n  = 1'b0;
				if ((ls_n == 3'd0) || (ls_n > lpnal_pkg::LEN_SIZE_MAX)) begin
					drop_n   = 1'b1;
					do_err   = 1'b1;
					err_code = lpnal_pkg::ST_BAD_SIZE;
				end
			end
			if (!drop_n) begin
				if ((sp_n == lpnal_pkg::PH_LEN) && (lseen_n == 3'd0)
						&& (sl_n <= {29'd0, ls_n}))
					sp_n = lpnal_pkg::PH_TAIL;
				if (sp_n == lpnal_pkg::PH_LEN) begin
					if (lseen_n == 3'd0)
						nal_n = '0;
					nal_n   = {nal_n[lpnal_pkg::LEN_W-9:0], data_byte};
					lseen_n = lseen_n + 3'd1;
					sl_n    = sl_n - 32'd1;
					if (lseen_n >= ls_n) begin
						lseen_n = '0;
						sum4    = {1'b0, nal_n} + 33'd4;
						if (nal_n > sl_n) begin
							drop_n   = 1'b1;
							do_err   = 1'b1;
							err_code = lpnal_pkg::ST_TOO_LONG;
						end else if (sum4 > {9'd0, ol_n}) begin
							drop_n   = 1'b1;
							do_err   = 1'b1;
							err_code = lpnal_pkg::ST_OVERFLOW;
						end else begin
							do_start = 1'b1;
							ol_n     = ol_n - sum4[lpnal_pkg::CAP_W-1:0];
							sp_n     = (nal_n != '0) ? lpnal_pkg::PH_BODY : lpnal_pkg::PH_LEN;
						end
					end
				end else if (sp_n == lpnal_pkg::PH_BODY) begin
					do_byte = 1'b1;
					nal_n   = nal_n - 32'd1;
					if (sl_n != '0)
						sl_n = sl_n - 32'd1;
					if (nal_n == '0)
						sp_n = lpnal_pkg::PH_LEN;
				end else begin
					if (sl_n != '0)
						sl_n = sl_n - 32'd1;
				end
			end
			if (last_byte) begin
				do_cut  = !drop_n && (sp_n == lpnal_pkg::PH_BODY) && (nal_n != '0);
				sp_n    = lpnal_pkg::PH_LEN;
				sl_n    = '0;
				lseen_n = '0;
				nal_n   = '0;
				drop_n  = 1'b0;
				ol_n    = cap_q;
			end
		end
	end

	// a last byte that produced nothing still closes with a bare marker result
	assign silent = last_byte && !(do_start || do_byte || do_err || do_cut);

	always_comb begin
		cmd.start     = do_start;
		cmd.r1_valid  = do_byte || do_err || silent;
		cmd.r1_has    = do_byte;
		cmd.r1_byte   = do_byte ? data_byte : 8'h00;
		cmd.r1_status = do_err ? err_code : lpnal_pkg::ST_OK;
		cmd.cut       = do_cut;
		cmd.last      = last_byte;
		cmd_valid     = accept && (do_start || cmd.r1_valid || do_cut);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sphase_q <= lpnal_pkg::PH_LEN;
			lseen_q  <= '0;
			nal_q    <= '0;
			sl_q     <= '0;
			cap_q    <= 24'h010000;
			ol_q     <= 24'h010000;
			ls_q     <= '0;
			rp_q     <= lpnal_pkg::RP_HEADER;
			ridx_q   <= '0;
			sets_q   <= '0;
			ent_q    <= '0;
			drop_q   <= 1'b0;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
			ol_q  <= cfg_data;
		end else if (accept) begin
			sphase_q <= sp_n;
			lseen_q  <= lseen_n;
			nal_q    <= nal_n;
			sl_q     <= sl_n;
			ol_q     <= ol_n;
			ls_q     <= ls_n;
			rp_q     <= rp_n;
			ridx_q   <= ridx_n;
			sets_q   <= sets_n;
			ent_q    <= ent_n;
			drop_q   <= drop_n;
		end
	end

endmodule

>>> src/lpnal_cmdq.sv
// Short command queue between the front and back ends.
// Depends on lpnal_pkg for the command type.
module lpnal_cmdq #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  lpnal_pkg::cmd_t wr_cmd,
	input  logic            rd,
	output lpnal_pkg::cmd_t head,
	output logic            q_full,
	output logic            q_empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	lpnal_pkg::cmd_t    slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr, do_rd;

	assign q_full  = (count_q == CNT_W'(DEPTH));
	assign q_empty = (count_q == '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CNT_W'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

>>> src/lpnal_back.sv
// Back end: expands queued commands into result items, one per cycle unless held.
// Depends on lpnal_pkg; holds the output register of the block.
module lpnal_back (
	input  logic            clk,
	input  logic            arst_n,
	input  lpnal_pkg::cmd_t head,
	input  logic            q_empty,
	output logic            q_rd,
	input  logic            pop,
	output logic            empty,
	output logic            has_byte,
	output logic [7:0]      out_byte,
	output logic [1:0]      status,
	output logic            end_mark
);

	logic [2:0] step_q;
	logic [2:0] n_start, total;
	logic       out_valid_q;
	logic       load, final_step;
	logic       r_has, r_end;
	logic [7:0] r_byte;
	logic [1:0] r_status;

	assign n_start    = head.start ? lpnal_pkg::START_BYTES : 3'd0;
	assign total      = n_start + {2'b00, head.r1_valid} + {2'b00, head.cut};
	assign final_step = (step_q == total - 3'd1);
	assign load       = !q_empty && (!out_valid_q || pop);
	assign q_rd       = load && final_step;
	assign empty      = !out_valid_q;

	// order within one command: start code, data byte or error, then cut-short error
	always_comb begin
		r_end = final_step && head.last;
		if (step_q < n_start) begin
			r_has    = 1'b1;
			r_byte   = (step_q == lpnal_pkg::START_BYTES - 3'd1) ? lpnal_pkg::START_LAST : 8'h00;
			r_status = lpnal_pkg::ST_OK;
		end else if (head.r1_valid && (step_q == n_start)) begin
			r_has    = head.r1_has;
			r_byte   = head.r1_byte;
			r_status = head.r1_status;
		end else begin
			r_has    = 1'b0;
			r_byte   = 8'h00;
			r_status = lpnal_pkg::ST_TOO_LONG;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			has_byte <= r_has;
			out_byte <= r_byte;
			status   <= r_status;
			end_mark <= r_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (load)
				step_q <= final_step ? 3'd0 : step_q + 3'd1;
		end
	end

endmodule
